### sv/sfs_pkg.sv
// sfs_pkg: shared types, register indexes, item kinds and reset values
// for the sprite frame sequencer. No dependencies.
`default_nettype none
package sfs_pkg;

  localparam int SEQ_DEPTH_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 16;
  localparam int KIND_W        = 2;
  localparam int CNT_W         = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_TOTAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_REVERSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIDIRECTIONAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONCE_LOOPS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH    = 3'd7;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd2;

  typedef struct packed {
    logic [7:0]  frames_total;
    logic [15:0] frame_delay;
    logic [7:0]  first_frame;
    logic [8:0]  last_frame;      // two's complement, negative = frames_total - 1
    logic        start_reverse;
    logic        bidirectional;
    logic [7:0]  once_loops;
    logic [4:0]  sequence_length;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    frames_total:    8'd1,
    frame_delay:     16'd64,
    first_frame:     8'd0,
    last_frame:      9'h1FF,
    start_reverse:   1'b0,
    bidirectional:   1'b0,
    once_loops:      8'd0,
    sequence_length: 5'd0
  };

  typedef struct packed {
    logic       finished;
    logic       running_reverse;
    logic [7:0] frame_index;
  } res_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

### sv/sprite_frame_sequencer.sv
// Sprite frame sequencer: a stream of tick, restart and load beats in, one
// result beat per input beat out. Channels:
//   in_*  : in_tuser = kind (tick, restart, load); in_tdata carries elapsed
//           ticks, table slot and table frame.
//   out_* : frame shown, running backwards, finished.
//   cfg_* : register writes by index, always ready; write only while idle.
// A new input beat is accepted only once the previous one has been pushed
// to the output register. Each countdown reload is a step state in plain
// counting, or a step state and a sequence table RAM read in sequence mode
// (no read once finished). A restart in sequence mode first reads table
// entry 0. The result appears on out_tvalid in the cycle after the item's
// last working cycle.
// The result sits in an output register; while the receiver stalls, the
// next beat is still accepted and worked on, and its result waits until
// the register empties.
// Reset loads the register defaults and the matching sequencer state; the
// sequence table is not cleared and holds no data until loaded.
`default_nettype none
module sprite_frame_sequencer #(
  parameter int SEQ_DEPTH = sfs_pkg::SEQ_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [15:0] elapsed_ticks, [19:16] entry_index, [27:20] entry_frame, zero pad
  input  wire logic [sfs_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [sfs_pkg::KIND_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [7:0] frame_index, [8] running_reverse, [9] finished, zero pad
  output logic [sfs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfs_pkg::*;

  localparam int POS_W = addr_w(SEQ_DEPTH);

  cfg_t             cfg;
  res_t             res;
  logic             res_push;
  logic             res_free;
  logic             ram_we;
  logic [POS_W-1:0] ram_wr_addr;
  logic [7:0]       ram_wr_data;
  logic [POS_W-1:0] ram_rd_addr;
  logic [7:0]       ram_rd_data;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;

  sfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfs_ram #(
    .WIDTH  (8),
    .DEPTH  (SEQ_DEPTH),
    .ADDR_W (POS_W)
  ) u_seq_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  sfs_ctrl #(
    .SEQ_DEPTH (SEQ_DEPTH),
    .POS_W     (POS_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_kind          (in_tuser),
    .in_elapsed_ticks (in_tdata[15:0]),
    .in_entry_index   (in_tdata[19:16]),
    .in_entry_frame   (in_tdata[27:20]),
    .ram_we           (ram_we),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data),
    .res              (res),
    .res_push         (res_push),
    .res_free         (res_free)
  );

  // output register
  assign res_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), out_res_r};

endmodule
`default_nettype wire

### sv/sfs_ram.sv
// sfs_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module sfs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### sv/sfs_cfg_regs.sv
// sfs_cfg_regs: configuration register file behind the write channel.
// Depends on sfs_pkg.
`default_nettype none
module sfs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output sfs_pkg::cfg_t                      cfg
);
  import sfs_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAMES_TOTAL:  cfg_nxt.frames_total    = cfg_data[7:0];
        REG_FRAME_DELAY:   cfg_nxt.frame_delay     = cfg_data;
        REG_FIRST_FRAME:   cfg_nxt.first_frame     = cfg_data[7:0];
        REG_LAST_FRAME:    cfg_nxt.last_frame      = cfg_data[8:0];
        REG_START_REVERSE: cfg_nxt.start_reverse   = cfg_data[0];
        REG_BIDIRECTIONAL: cfg_nxt.bidirectional   = cfg_data[0];
        REG_ONCE_LOOPS:    cfg_nxt.once_loops      = cfg_data[7:0];
        REG_SEQ_LENGTH:    cfg_nxt.sequence_length = cfg_data[4:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/sfs_ctrl.sv
// sfs_ctrl: sequencer state and control FSM; reads and writes the sequence
// table RAM. Depends on sfs_pkg.
`default_nettype none
module sfs_ctrl #(
  parameter int SEQ_DEPTH = sfs_pkg::SEQ_DEPTH_DEF,
  parameter int POS_W     = sfs_pkg::addr_w(SEQ_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sfs_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [sfs_pkg::KIND_W-1:0] in_kind,
  input  wire logic [15:0]               in_elapsed_ticks,
  input  wire logic [3:0]                in_entry_index,
  input  wire logic [7:0]                in_entry_frame,
  output logic                           ram_we,
  output logic [POS_W-1:0]               ram_wr_addr,
  output logic [7:0]                     ram_wr_data,
  output logic [POS_W-1:0]               ram_rd_addr,
  input  wire logic [7:0]                ram_rd_data,
  output sfs_pkg::res_t                  res,
  output logic                           res_push,
  input  wire logic                      res_free
);
  import sfs_pkg::*;

  localparam int LEN_W = $clog2(SEQ_DEPTH + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_STEP    = 3'd1;
  localparam logic [2:0] ST_RD_STEP = 3'd2;
  localparam logic [2:0] ST_RD_FIN  = 3'd3;
  localparam logic [2:0] ST_FIN     = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [7:0]              cur_r, cur_nxt;
  logic                    rev_r, rev_nxt;
  logic [7:0]              loops_r, loops_nxt;
  logic                    done_r, done_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  pos_inc;
  logic              seq_wrap;
  logic [7:0]        cl_loops;
  logic              counted;
  logic [7:0]        ft_adj;
  logic signed [9:0] eff_last, cur_s, first_s, dn_s, up_s, step_s;
  logic              step_rev, step_cnt;
  logic [7:0]        step_frame;
  logic              cnt_le0;
  logic              accept;

  // effective sequence length
  always_comb begin
    if (32'(cfg.sequence_length) > SEQ_DEPTH) begin
      len = LEN_W'(SEQ_DEPTH);
    end else begin
      len = LEN_W'(cfg.sequence_length);
    end
  end

  assign pos_inc  = LEN_W'(pos_r) + LEN_W'(1);
  assign seq_wrap = (pos_inc >= len);
  assign cl_loops = (loops_r != 8'd0) ? (loops_r - 8'd1) : 8'd0;

  // plain counting step
  assign ft_adj   = (cfg.frames_total == 8'd0) ? 8'd1 : cfg.frames_total;
  assign eff_last = cfg.last_frame[8] ? ($signed({2'b00, ft_adj}) - 10'sd1)
                                      : $signed({1'b0, cfg.last_frame});
  assign cur_s    = $signed({2'b00, cur_r});
  assign first_s  = $signed({2'b00, cfg.first_frame});
  assign dn_s     = cur_s - 10'sd1;
  assign up_s     = cur_s + 10'sd1;

  always_comb begin
    step_rev = rev_r;
    step_cnt = 1'b0;
    if (rev_r) begin
      step_s = dn_s;
      if (dn_s < first_s) begin
        step_cnt = 1'b1;
        if (cfg.bidirectional) begin
          step_rev = 1'b0;
          step_s   = up_s;
        end else begin
          step_s   = eff_last;
        end
      end
    end else begin
      step_s = up_s;
      if (up_s > eff_last) begin
        if (cfg.bidirectional) begin
          step_rev = 1'b1;
          step_s   = dn_s;
        end else begin
          step_s   = first_s;
          step_cnt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (step_s[9]) begin
      step_frame = 8'd0;
    end else if (step_s > 10'sd255) begin
      step_frame = 8'hFF;
    end else begin
      step_frame = step_s[7:0];
    end
  end

  assign cnt_le0  = cnt_r[CNT_W-1] || (cnt_r == '0);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign res.frame_index     = cur_r;
  assign res.running_reverse = rev_r;
  assign res.finished        = done_r;

  assign ram_wr_addr = POS_W'(in_entry_index);
  assign ram_wr_data = in_entry_frame;

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    rev_nxt     = rev_r;
    loops_nxt   = loops_r;
    done_nxt    = done_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    counted     = 1'b0;
    ram_we      = 1'b0;
    ram_rd_addr = pos_r;
    res_push    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_kind == KIND_TICK) begin
            if (cfg.frame_delay != 16'd0) begin
              cnt_nxt   = cnt_r - $signed({2'b00, in_elapsed_ticks});
              state_nxt = ST_STEP;
            end else begin
              state_nxt = ST_FIN;
            end
          end else if (in_kind == KIND_RESTART) begin
            rev_nxt     = cfg.start_reverse;
            loops_nxt   = cfg.once_loops;
            done_nxt    = 1'b0;
            pos_nxt     = '0;
            cnt_nxt     = $signed({2'b00, cfg.frame_delay});
            ram_rd_addr = '0;
            if (len != '0) begin
              state_nxt = ST_RD_FIN;
            end else begin
              cur_nxt   = cfg.first_frame;
              state_nxt = ST_FIN;
            end
          end else if (in_kind == KIND_LOAD) begin
            ram_we    = (32'(in_entry_index) < SEQ_DEPTH);
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_STEP: begin
        if (cnt_le0) begin
          cnt_nxt = cnt_r + $signed({2'b00, cfg.frame_delay});
          if (!done_r) begin
            if (len != '0) begin
              pos_nxt     = seq_wrap ? '0 : pos_inc[POS_W-1:0];
              counted     = seq_wrap;
              ram_rd_addr = pos_nxt;
              state_nxt   = ST_RD_STEP;
            end else begin
              cur_nxt = step_frame;
              rev_nxt = step_rev;
              counted = step_cnt;
            end
          end
        end else if (res_free) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_STEP: begin
        cur_nxt   = ram_rd_data;
        state_nxt = ST_STEP;
      end
      ST_RD_FIN: begin
        cur_nxt   = ram_rd_data;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (res_free) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // counted wrap in once mode
    if (counted && (cfg.once_loops != 8'd0)) begin
      loops_nxt = cl_loops;
      if (cl_loops == 8'd0) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= CFG_RST.first_frame;
      rev_r   <= CFG_RST.start_reverse;
      loops_r <= CFG_RST.once_loops;
      done_r  <= 1'b0;
      pos_r   <= '0;
      cnt_r   <= $signed({2'b00, CFG_RST.frame_delay});
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      rev_r   <= rev_nxt;
      loops_r <= loops_nxt;
      done_r  <= done_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_done_loops: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (loops_r == 8'd0))
    else $error("finished set with loops left");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res_free)
    else $error("result pushed into a full output stage");

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (state_r == ST_IDLE))
    else $error("no return to idle after result");

  a_rd_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_STEP) |=> (state_r == ST_STEP))
    else $error("table read did not return to stepping");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < SEQ_DEPTH)
    else $error("sequence position beyond table");

endmodule
`default_nettype wire

### verif/tb.sv
// tb: self-checking testbench for sprite_frame_sequencer; drives tick, restart and
// table load beats, predicts each result beat and compares it field by field.
// Depends on sfs_pkg and the sprite_frame_sequencer RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfs_pkg::*;

  localparam int TABLE_SLOTS = SEQ_DEPTH_DEF;
  localparam int RANDOM_BEATS = 700;
  localparam int SETTLE_LIMIT = 100000;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [KIND_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sprite_frame_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // sequencer mirror
  cfg_t regs;
  logic [7:0] shown_frame;
  logic backwards;
  logic [7:0] loops_remaining;
  logic finished_flag;
  int seq_slot;
  logic signed [CNT_W-1:0] tick_budget;
  logic [7:0] seq_mem [TABLE_SLOTS];

  res_t frames_due[$];
  int errors = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int n_ticks = 0, n_restarts = 0, n_loads = 0, n_spare = 0;
  int n_results = 0, n_finished = 0, n_backwards = 0, n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL sprite_frame_sequencer");
    $finish;
  end

  function automatic int top_frame();
    if (!regs.last_frame[8]) return int'(regs.last_frame);
    return (regs.frames_total == 8'd0) ? 0 : int'(regs.frames_total) - 1;
  endfunction

  function automatic int table_used();
    return (int'(regs.sequence_length) > TABLE_SLOTS) ? TABLE_SLOTS
                                                       : int'(regs.sequence_length);
  endfunction

  function automatic void use_up_loop();
    if (regs.once_loops == 8'd0) return;
    if (loops_remaining != 8'd0) loops_remaining--;
    if (loops_remaining == 8'd0) finished_flag = 1'b1;
  endfunction

  function automatic void step_frame();
    int used;
    int nxt;
    used = table_used();
    nxt = int'(shown_frame);
    if (finished_flag) return;
    if (used != 0) begin
      seq_slot++;
      if (seq_slot >= used) begin
        seq_slot = 0;
        use_up_loop();
      end
      shown_frame = seq_mem[seq_slot];
      return;
    end
    if (backwards) begin
      nxt--;
      if (nxt < int'(regs.first_frame)) begin
        if (regs.bidirectional) begin
          backwards = 1'b0;
          nxt += 2;
        end else begin
          nxt = top_frame();
        end
        use_up_loop();
      end
    end else begin
      nxt++;
      if (nxt > top_frame()) begin
        if (regs.bidirectional) begin
          backwards = 1'b1;
          nxt -= 2;
        end else begin
          nxt = int'(regs.first_frame);
          use_up_loop();
        end
      end
    end
    shown_frame = (nxt < 0) ? 8'd0 : (nxt > 255) ? 8'd255 : nxt[7:0];
  endfunction

  function automatic void reload_state();
    backwards = regs.start_reverse;
    loops_remaining = regs.once_loops;
    finished_flag = 1'b0;
    seq_slot = 0;
    tick_budget = $signed({2'b00, regs.frame_delay});
    shown_frame = (table_used() != 0) ? seq_mem[0] : regs.first_frame;
  endfunction

  function automatic res_t predict_frame(input logic [KIND_W-1:0] kind,
                                         input logic [15:0] elapsed,
                                         input logic [3:0] slot, input logic [7:0] frm);
    res_t r;
    case (kind)
      KIND_TICK: begin
        if (regs.frame_delay != 16'd0) begin
          tick_budget = tick_budget - $signed({2'b00, elapsed});
          while (tick_budget <= 0) begin
            step_frame();
            tick_budget = tick_budget + $signed({2'b00, regs.frame_delay});
          end
        end
      end
      KIND_RESTART: reload_state();
      KIND_LOAD: seq_mem[slot] = frm;
      default: ;
    endcase
    r.frame_index = shown_frame;
    r.running_reverse = backwards;
    r.finished = finished_flag;
    return r;
  endfunction

  // result beat checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[9:0]);
      n_results++;
      if (got.finished) n_finished++;
      if (got.running_reverse) n_backwards++;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected result beat, got frame %0d rev %0b fin %0b",
                 $time, got.frame_index, got.running_reverse, got.finished);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (got.frame_index !== want.frame_index) begin
          $display("%0t: frame_index mismatch, expected %0d actual %0d",
                   $time, want.frame_index, got.frame_index);
          errors++;
        end
        if (got.running_reverse !== want.running_reverse) begin
          $display("%0t: running_reverse mismatch, expected %0b actual %0b",
                   $time, want.running_reverse, got.running_reverse);
          errors++;
        end
        if (got.finished !== want.finished) begin
          $display("%0t: finished mismatch, expected %0b actual %0b",
                   $time, want.finished, got.finished);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    rx_mode_e mode;
    int run;
    out_tready = 1'b0;
    mode = RX_OPEN;
    run = 0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        run = $urandom_range(20, 300);
      end
      run--;
      case (mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_tready <= ($urandom_range(0, 5) == 0);
        default: out_tready <= ((run % 16) < 10);
      endcase
    end
  end

  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [15:0] elapsed,
                           input logic [3:0] slot, input logic [7:0] frm);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'd0, frm, slot, elapsed};
    do @(posedge clk); while (!in_tready);
    frames_due.push_back(predict_frame(kind, elapsed, slot, frm));
    case (kind)
      KIND_TICK: n_ticks++;
      KIND_RESTART: n_restarts++;
      KIND_LOAD: n_loads++;
      default: n_spare++;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (frames_due.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, frames_due.size());
      errors++;
      frames_due.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic set_regs(input cfg_t c);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    settle();
    for (int r = 0; r < 8; r++) begin
      idx = CFG_IDX_W'(r);
      case (idx)
        REG_FRAMES_TOTAL: data = {8'd0, c.frames_total};
        REG_FRAME_DELAY: data = c.frame_delay;
        REG_FIRST_FRAME: data = {8'd0, c.first_frame};
        REG_LAST_FRAME: data = {7'd0, c.last_frame};
        REG_START_REVERSE: data = {15'd0, c.start_reverse};
        REG_BIDIRECTIONAL: data = {15'd0, c.bidirectional};
        REG_ONCE_LOOPS: data = {8'd0, c.once_loops};
        REG_SEQ_LENGTH: data = {11'd0, c.sequence_length};
        default: data = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    regs = c;
    n_settings++;
  endtask

  function automatic logic [15:0] pick_elapsed();
    if (regs.frame_delay == 16'd0 || regs.frame_delay >= 16'd4096) begin
      case ($urandom_range(0, 9))
        0: return 16'd0;
        1: return 16'hFFFF;
        default: return 16'($urandom_range(0, 65535));
      endcase
    end
    return 16'($urandom_range(0, 3 * int'(regs.frame_delay)));
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    case ($urandom_range(0, 9))
      0: c.frames_total = 8'd0;
      1: c.frames_total = 8'd255;
      default: c.frames_total = 8'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 9))
      0: c.frame_delay = 16'd0;
      1: c.frame_delay = 16'hFFFF;
      2: c.frame_delay = 16'($urandom_range(4096, 65535));
      3: c.frame_delay = 16'd1;
      default: c.frame_delay = 16'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 9))
      0: c.first_frame = 8'd0;
      1: c.first_frame = 8'd255;
      2: c.first_frame = 8'($urandom_range(0, 255));
      default: c.first_frame = 8'($urandom_range(0, 6));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: c.last_frame = 9'h1FF;
      3: c.last_frame = {1'b1, 8'($urandom_range(0, 255))};
      4: c.last_frame = 9'd255;
      5: c.last_frame = 9'($urandom_range(0, 255));
      default: c.last_frame = 9'(int'(c.first_frame) + $urandom_range(0, 8)) & 9'h0FF;
    endcase
    c.start_reverse = 1'($urandom_range(0, 1));
    c.bidirectional = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c.once_loops = 8'd0;
      5: c.once_loops = 8'd255;
      6: c.once_loops = 8'($urandom_range(0, 255));
      default: c.once_loops = 8'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c.sequence_length = 5'd0;
      5: c.sequence_length = 5'd16;
      6: c.sequence_length = 5'($urandom_range(17, 31));
      default: c.sequence_length = 5'($urandom_range(1, 15));
    endcase
    return c;
  endfunction

  // defaults after reset, ignored kind, tick extremes, loads of first and last table entries
  task automatic test_defaults_and_loads();
    send_beat(KIND_SPARE, 16'hFFFF, 4'hF, 8'hFF);
    send_beat(KIND_TICK, 16'd0, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'hFFFF, 4'hF, 8'hFF);
    send_beat(KIND_LOAD, 16'hFFFF, 4'd0, 8'd255);
    send_beat(KIND_LOAD, 16'd0, 4'd1, 8'd0);
    send_beat(KIND_LOAD, 16'h5A5A, 4'd2, 8'hAA);
    send_beat(KIND_LOAD, 16'hA5A5, 4'd15, 8'h55);
  endtask

  // reverse start, bounce at both ends
  task automatic test_bounce_reverse();
    cfg_t c;
    c = CFG_RST;
    c.frames_total = 8'd8;
    c.frame_delay = 16'd1;
    c.first_frame = 8'd2;
    c.start_reverse = 1'b1;
    c.bidirectional = 1'b1;
    set_regs(c);
    send_beat(KIND_RESTART, 16'd0, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'd1, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'd5, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'd12, 4'd0, 8'd0);
  endtask

  // once mode runs out of loops and freezes
  task automatic test_once_finish();
    cfg_t c;
    c = CFG_RST;
    c.frames_total = 8'd4;
    c.frame_delay = 16'd3;
    c.last_frame = 9'd2;
    c.once_loops = 8'd2;
    set_regs(c);
    send_beat(KIND_RESTART, 16'd0, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'd9, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'd9, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'd3, 4'd0, 8'd0);
  endtask

  // three-entry sequence, longest delay
  task automatic test_sequence_table();
    cfg_t c;
    c = CFG_RST;
    c.frame_delay = 16'hFFFF;
    c.once_loops = 8'd255;
    c.sequence_length = 5'd3;
    set_regs(c);
    send_beat(KIND_RESTART, 16'd0, 4'd0, 8'd0);
    repeat (3) send_beat(KIND_TICK, 16'hFFFF, 4'd0, 8'd0);
  endtask

  // zero delay idles; zero strip length, negative last and top first frame
  task automatic test_idle_degenerate();
    cfg_t c;
    c = CFG_RST;
    c.frames_total = 8'd0;
    c.frame_delay = 16'd0;
    c.first_frame = 8'd255;
    c.last_frame = 9'h100;
    c.bidirectional = 1'b1;
    set_regs(c);
    send_beat(KIND_RESTART, 16'd0, 4'd0, 8'd0);
    send_beat(KIND_TICK, 16'hFFFF, 4'd0, 8'd0);
    c.frame_delay = 16'd2;
    set_regs(c);
    send_beat(KIND_TICK, 16'd4, 4'd0, 8'd0);
  endtask

  task automatic test_random_traffic();
    int order [TABLE_SLOTS];
    int j;
    int tmp;
    int counted;
    logic [KIND_W-1:0] kind;
    for (int i = 0; i < TABLE_SLOTS; i++) order[i] = i;
    for (int i = TABLE_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    // fill the whole table before any long sequence can read it
    for (int i = 0; i < TABLE_SLOTS; i++)
      send_beat(KIND_LOAD, 16'($urandom), 4'(order[i]), 8'($urandom));
    counted = TABLE_SLOTS;
    while (counted < RANDOM_BEATS) begin
      set_regs(random_regs());
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        send_beat(KIND_RESTART, 16'($urandom), 4'($urandom), 8'($urandom));
        counted++;
      end
      repeat ($urandom_range(10, 50)) begin
        case ($urandom_range(0, 19))
          0, 1: kind = KIND_RESTART;
          2, 3: kind = KIND_LOAD;
          4: kind = KIND_SPARE;
          default: kind = KIND_TICK;
        endcase
        if (kind == KIND_TICK)
          send_beat(kind, pick_elapsed(), 4'($urandom), 8'($urandom));
        else
          send_beat(kind, 16'($urandom), 4'($urandom), 8'($urandom));
        if (kind != KIND_SPARE) counted++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_TICK;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAMES_TOTAL;
    cfg_data = '0;
    regs = CFG_RST;
    for (int i = 0; i < TABLE_SLOTS; i++) seq_mem[i] = 8'd0;
    reload_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_defaults_and_loads();
    test_bounce_reverse();
    test_once_finish();
    test_sequence_table();
    test_idle_degenerate();
    test_random_traffic();

    settle();
    repeat (10) @(negedge clk);
    $display("Run covered %0d ticks, %0d restarts, %0d table loads, %0d ignored beats, %0d settings.",
             n_ticks, n_restarts, n_loads, n_spare, n_settings);
    $display("Checked %0d result beats: %0d finished, %0d stepping backwards.",
             n_results, n_finished, n_backwards);
    if (errors == 0) begin
      $display("PASS sprite_frame_sequencer");
    end else begin
      $display("FAIL sprite_frame_sequencer");
    end
    $finish;
  end

endmodule

### sim.f
sv/sfs_pkg.sv
sv/sfs_ram.sv
sv/sfs_cfg_regs.sv
sv/sfs_ctrl.sv
sv/sprite_frame_sequencer.sv
verif/tb.sv
